// File: rtl/core/frq_pkg.sv
package frq_pkg;

  // Defaults for the top-level parameters
  localparam int SlotsDef     = 16;
  localparam int MaxFrameDef  = 1536;

  // Fixed field widths
  localparam int CfgW   = 5;
  localparam int ByteW  = 8;
  localparam int FlenW  = 11;
  localparam int CountW = 4;

  // Configuration register indexes
  localparam logic CFG_SLOT_COUNT = 1'b0;
  localparam logic CFG_THRESHOLD  = 1'b1;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_PULL = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DROP  = 2'd2,
    ST_TRUNC = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [ByteW-1:0]  data_out;
    logic              data_valid;
    logic              last_out;
    logic [FlenW-1:0]  frame_length;
    logic [CountW-1:0] frames_queued;
    logic [CountW-1:0] slots_free;
    logic              above_threshold;
    status_e           status;
  } res_t;

endpackage

// File: rtl/core/frq_store.sv
module frq_store import frq_pkg::*; #(
  parameter int SLOTS           = SlotsDef,
  parameter int MAX_FRAME_BYTES = MaxFrameDef,
  localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int AW = $clog2(SLOTS * MAX_FRAME_BYTES),
  localparam int LW = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic [PW-1:0]    rd_slot_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [ByteW-1:0] wr_byte_i,
  input  logic             len_we_i,
  input  logic [PW-1:0]    len_slot_i,
  input  logic [LW-1:0]    len_i,
  output logic [ByteW-1:0] byte_o,
  output logic [LW-1:0]    len_o
);

  localparam int Depth = SLOTS * MAX_FRAME_BYTES;

  logic [ByteW-1:0] frame_mem [Depth];
  logic [LW-1:0]    len_mem   [SLOTS];
  logic [ByteW-1:0] byte_q;
  logic [LW-1:0]    len_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      frame_mem[wr_addr_i] <= wr_byte_i;
    end
    if (rd_en_i) begin
      byte_q <= frame_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_we_i) begin
      len_mem[len_slot_i] <= len_i;
    end
    if (rd_en_i) begin
      len_q <= len_mem[rd_slot_i];
    end
  end

  assign byte_o = byte_q;
  assign len_o  = len_q;

endmodule

// File: rtl/core/frq_ctrl.sv
module frq_ctrl import frq_pkg::*; #(
  parameter int SLOTS           = SlotsDef,
  parameter int MAX_FRAME_BYTES = MaxFrameDef,
  localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int AW = $clog2(SLOTS * MAX_FRAME_BYTES),
  localparam int LW = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CfgW-1:0]  cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cmd_e             in_cmd_i,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             in_last_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o,
  output logic             rd_en_o,
  output logic [AW-1:0]    rd_addr_o,
  output logic [PW-1:0]    rd_slot_o,
  output logic             wr_en_o,
  output logic [AW-1:0]    wr_addr_o,
  output logic [ByteW-1:0] wr_byte_o,
  output logic             len_we_o,
  output logic [PW-1:0]    len_slot_o,
  output logic [LW-1:0]    len_o,
  input  logic [ByteW-1:0] byte_i,
  input  logic [LW-1:0]    len_i
);

  localparam int QW = ((PW > CfgW) ? PW : CfgW) + 1;

  state_e state_q, state_d;
  logic [CfgW-1:0]  slot_count_q, threshold_q;
  logic [PW-1:0]    ws_q, ws_d, rs_q, rs_d;
  logic [LW-1:0]    wo_q, wo_d, ro_q, ro_d;
  logic             drop_q, drop_d;
  cmd_e             cmd_q;
  logic [ByteW-1:0] byte_q;
  logic             last_q;

  logic [QW-1:0]    n;
  logic             fire;
  logic [LW-1:0]    ro_rd;

  function automatic logic [QW-1:0] count(logic [PW-1:0] w, logic [PW-1:0] r,
                                          logic [QW-1:0] nn);
    logic [QW-1:0] we, re;
    we = QW'(w);
    re = QW'(r);
    if (we >= re) return we - re;
    return we + nn - re;
  endfunction

  // Effective slot count saturates at the memory size
  assign n = (int'(slot_count_q) > SLOTS) ? QW'(SLOTS) : QW'(slot_count_q);

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_EXEC);
  assign fire        = res_valid_o && res_ready_i;

  // Read the head byte and its length at the item's accept edge
  assign ro_rd     = (int'(ro_q) >= MAX_FRAME_BYTES) ? LW'(MAX_FRAME_BYTES - 1) : ro_q;
  assign rd_en_o   = in_valid_i && in_ready_o;
  assign rd_addr_o = AW'(rs_q) * AW'(MAX_FRAME_BYTES) + AW'(ro_rd);
  assign rd_slot_o = rs_q;
  assign wr_addr_o = AW'(ws_q) * AW'(MAX_FRAME_BYTES) + AW'(wo_q);
  assign wr_byte_o = byte_q;
  assign len_slot_o = ws_q;

  always_comb begin
    logic [QW-1:0] q_pre, q_post, ws_inc, rs_inc;
    logic [LW-1:0] wo_inc, ro_inc;
    logic          inert, drop_now, room;
    inert    = (n == '0);
    q_pre    = count(ws_q, rs_q, n);
    ws_inc   = QW'(ws_q) + QW'(1);
    rs_inc   = QW'(rs_q) + QW'(1);
    room     = (int'(wo_q) < MAX_FRAME_BYTES);
    wo_inc   = room ? wo_q + LW'(1) : wo_q;
    ro_inc   = ro_q + LW'(1);
    drop_now = drop_q || (wo_q == '0 && q_pre >= n - QW'(1));

    state_d  = state_q;
    ws_d     = ws_q;
    rs_d     = rs_q;
    wo_d     = wo_q;
    ro_d     = ro_q;
    drop_d   = drop_q;
    wr_en_o  = 1'b0;
    len_we_o = 1'b0;
    len_o    = wo_inc;
    res_o    = '0;
    res_o.status = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_q == CMD_PUSH) begin
          if (!inert) begin
            if (drop_now) begin
              res_o.status = ST_DROP;
              drop_d = !last_q;
            end else begin
              wr_en_o = fire && room;
              if (!room) res_o.status = ST_TRUNC;
              wo_d = wo_inc;
              if (last_q) begin
                len_we_o = fire;
                wo_d = '0;
                ws_d = (ws_inc == n) ? '0 : PW'(ws_inc);
              end
            end
          end
        end else begin
          if (inert || q_pre == '0) begin
            res_o.status = ST_EMPTY;
          end else begin
            res_o.data_out     = byte_i;
            res_o.data_valid   = 1'b1;
            res_o.frame_length = FlenW'(len_i);
            if ((LW + 1)'(ro_q) + (LW + 1)'(1) >= (LW + 1)'(len_i)) begin
              res_o.last_out = 1'b1;
              ro_d = '0;
              rs_d = (rs_inc == n) ? '0 : PW'(rs_inc);
            end else begin
              ro_d = ro_inc;
            end
          end
        end
        q_post = count(ws_d, rs_d, n);
        res_o.frames_queued   = CountW'(q_post);
        res_o.slots_free      = inert ? '0 : CountW'(n - QW'(1) - q_post);
        res_o.above_threshold = !inert && (q_post >= QW'(threshold_q));
        if (fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= '0;
      threshold_q  <= '0;
      ws_q         <= '0;
      rs_q         <= '0;
      wo_q         <= '0;
      ro_q         <= '0;
      drop_q       <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SLOT_COUNT) begin
        slot_count_q <= cfg_data_i;
        ws_q         <= '0;
        rs_q         <= '0;
        wo_q         <= '0;
        ro_q         <= '0;
        drop_q       <= 1'b0;
      end else begin
        threshold_q  <= cfg_data_i;
      end
    end else if (fire) begin
      ws_q   <= ws_d;
      rs_q   <= rs_d;
      wo_q   <= wo_d;
      ro_q   <= ro_d;
      drop_q <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_o) begin
      cmd_q  <= in_cmd_i;
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

endmodule

// File: rtl/core/frame_ring_queue.sv
// Ring queue of whole network frames.
// Input stream (s_axis_*): one request per frame byte. tuser selects push
// (0) or pull (1); on a push tdata carries the byte and tlast marks the
// final byte of the frame, which commits it to the next slot.
// Output stream (m_axis_*): exactly one result per request, in order. It
// carries the pulled byte (tuser high when a byte was read, tlast on the
// final byte of the head frame), the head frame length, the queued frame
// count, the free slot count, the threshold flag and a status code: ok,
// pull on empty, frame dropped because the queue was full, or frame
// truncated at MAX_FRAME_BYTES.
// Timing: a request first reads the head byte and its length from the
// frame memory and length table (registered read) at its accept edge,
// then updates the pointers and writes back; one request is in flight at
// a time, so the next request is accepted only once this result is taken.
// Result: built in the execute state from the registered read and loaded
// into the output register when that register is free.
// Stall: a held result sits in the output register; the next request is
// still accepted and waits in the core until that register frees.
// Reset: pointers clear and slot_count is zero, so the block is inert
// until slot_count is written. Writing slot_count discards queued frames.
module frame_ring_queue import frq_pkg::*; #(
  parameter int SLOTS           = SlotsDef,
  parameter int MAX_FRAME_BYTES = MaxFrameDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration write port
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  // request stream
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // [7:0] data_in
  input  logic            s_axis_tuser,   // [0] command
  input  logic            s_axis_tlast,
  // result stream
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [31:0]     m_axis_tdata,   // [7:0] data_out, [18:8] frame_length,
                                          // [22:19] frames_queued, [26:23] slots_free,
                                          // [27] above_threshold, [29:28] status
  output logic            m_axis_tuser,   // [0] data_valid
  output logic            m_axis_tlast
);

  localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AW = $clog2(SLOTS * MAX_FRAME_BYTES);
  localparam int LW = $clog2(MAX_FRAME_BYTES + 1);

  logic             res_valid, res_ready;
  res_t             res, out_q;
  logic             out_valid_q;
  logic             rd_en, wr_en, len_we;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [PW-1:0]    rd_slot, len_slot;
  logic [ByteW-1:0] wr_byte, rd_byte;
  logic [LW-1:0]    len_wr, len_rd;

  frq_ctrl #(
    .SLOTS           (SLOTS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (cmd_e'(s_axis_tuser)),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_slot_o   (rd_slot),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_byte_o   (wr_byte),
    .len_we_o    (len_we),
    .len_slot_o  (len_slot),
    .len_o       (len_wr),
    .byte_i      (rd_byte),
    .len_i       (len_rd)
  );

  frq_store #(
    .SLOTS           (SLOTS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_store (
    .clk_i      (clk_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_slot_i  (rd_slot),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_byte_i  (wr_byte),
    .len_we_i   (len_we),
    .len_slot_i (len_slot),
    .len_i      (len_wr),
    .byte_o     (rd_byte),
    .len_o      (len_rd)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.data_valid;
  assign m_axis_tlast  = out_q.last_out;
  assign m_axis_tdata  = {2'b00, out_q.status, out_q.above_threshold, out_q.slots_free,
                          out_q.frames_queued, out_q.frame_length, out_q.data_out};

`ifndef ASSERT_OFF
  // A byte read from the head frame always reports a clean status
  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.data_valid |-> out_q.status == ST_OK)
    else $error("pulled byte reported with error status");

  // End of frame only ever marks a byte that was actually read
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.last_out |-> out_q.data_valid)
    else $error("last flag without data");

  // Only one request is in the core at a time
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !s_axis_tready)
    else $error("request accepted while another is in progress");

  // An accepted request always reaches the result stage next cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> res_valid)
    else $error("accepted request lost");
`endif

endmodule
